// ----- hw/rtl/utf8d_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8d_pkg
// shared types and constants of the utf-8 decoder: status codes, the job
// record passed from front to back, and configuration register layout
// ----------------------------------------------------------------------------
package utf8d_pkg;

    // result status codes
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_ILLEGAL = 2'd1;
    localparam logic [1:0] ST_TOOFEW  = 2'd2;

    // field widths
    localparam int BYTE_W = 8;
    localparam int CODE_W = 21;
    localparam int STAT_W = 2;
    localparam int SURR_W = 16;

    // apb layout
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam logic REG_IDX_UTF16_MODE = 1'b0;

    // default depth of the job queue
    localparam int QUEUE_DEPTH_DEF = 4;

    // surrogate bases
    localparam logic [SURR_W-1:0] SURR_HI_BASE = 16'hD7C0;
    localparam logic [SURR_W-1:0] SURR_LO_BASE = 16'hDC00;

    // one classified job: a single result, or a surrogate pair to expand
    typedef struct packed {
        logic [CODE_W-1:0] code;
        logic [STAT_W-1:0] status;
        logic              pair;
        logic              msg_end;
    } job_t;

endpackage

// ----- hw/rtl/utf8d_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8d_front
// accepts bytes, tracks the open sequence and message error state, and
// pushes one job per byte that yields a result
// ----------------------------------------------------------------------------
module utf8d_front (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               accept,
    input  logic [utf8d_pkg::BYTE_W-1:0]       byte_in,
    input  logic                               message_last,
    input  logic                               utf16_mode,
    output logic                               push,
    output utf8d_pkg::job_t                    job
);

    logic [2:0]                         needed_reg, needed_next;
    logic [2:0]                         seen_reg, seen_next;
    logic [utf8d_pkg::CODE_W-1:0]       partial_reg, partial_next;
    logic                               bad_reg, bad_next;
    logic                               failed_reg, failed_next;

    logic                               emit;
    logic [2:0]                         seen_inc;
    logic                               bad_cont;
    logic [utf8d_pkg::CODE_W-1:0]       partial_shift;

    assign seen_inc      = seen_reg + 3'd1;
    assign bad_cont      = bad_reg | (byte_in[7:6] != 2'b10);
    assign partial_shift = {partial_reg[utf8d_pkg::CODE_W-7:0], byte_in[5:0]};

    // byte classification and sequence state update
    always_comb begin
        needed_next  = needed_reg;
        seen_next    = seen_reg;
        partial_next = partial_reg;
        bad_next     = bad_reg;
        failed_next  = failed_reg;
        emit         = 1'b0;
        job.code     = '0;
        job.status   = utf8d_pkg::ST_OK;
        job.pair     = 1'b0;
        job.msg_end  = message_last;
        if (failed_reg) begin
            // discard rest of the message
            if (message_last) begin
                failed_next = 1'b0;
            end
        end else if (needed_reg == 3'd0) begin
            priority if (byte_in[7] == 1'b0) begin
                emit     = 1'b1;
                job.code = utf8d_pkg::CODE_W'(byte_in);
            end else if (byte_in[7:5] == 3'b110 || byte_in[7:4] == 4'b1110 ||
                         byte_in[7:3] == 5'b11110) begin
                if (message_last) begin
                    emit       = 1'b1;
                    job.status = utf8d_pkg::ST_TOOFEW;
                end else begin
                    seen_next = 3'd1;
                    bad_next  = 1'b0;
                    priority if (byte_in[7:5] == 3'b110) begin
                        needed_next  = 3'd2;
                        partial_next = utf8d_pkg::CODE_W'(byte_in[4:0]);
                    end else if (byte_in[7:4] == 4'b1110) begin
                        needed_next  = 3'd3;
                        partial_next = utf8d_pkg::CODE_W'(byte_in[3:0]);
                    end else begin
                        needed_next  = 3'd4;
                        partial_next = utf8d_pkg::CODE_W'(byte_in[2:0]);
                    end
                end
            end else begin
                // stray continuation or invalid lead
                emit        = 1'b1;
                job.status  = utf8d_pkg::ST_ILLEGAL;
                failed_next = ~message_last;
            end
        end else if (seen_inc >= needed_reg) begin
            // sequence complete
            emit         = 1'b1;
            needed_next  = 3'd0;
            seen_next    = 3'd0;
            partial_next = '0;
            bad_next     = 1'b0;
            if (bad_cont) begin
                job.status  = utf8d_pkg::ST_ILLEGAL;
                failed_next = ~message_last;
            end else begin
                job.code = partial_shift;
                job.pair = (needed_reg == 3'd4) && utf16_mode;
            end
        end else if (message_last) begin
            // message ended inside a sequence
            emit         = 1'b1;
            job.status   = utf8d_pkg::ST_TOOFEW;
            needed_next  = 3'd0;
            seen_next    = 3'd0;
            partial_next = '0;
            bad_next     = 1'b0;
        end else begin
            seen_next    = seen_inc;
            partial_next = partial_shift;
            bad_next     = bad_cont;
        end
    end

    assign push = accept & emit;

    // state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            needed_reg  <= 3'd0;
            seen_reg    <= 3'd0;
            partial_reg <= '0;
            bad_reg     <= 1'b0;
            failed_reg  <= 1'b0;
        end else if (accept) begin
            needed_reg  <= needed_next;
            seen_reg    <= seen_next;
            partial_reg <= partial_next;
            bad_reg     <= bad_next;
            failed_reg  <= failed_next;
        end
    end

endmodule

// ----- hw/rtl/utf8d_queue.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8d_queue
// small register fifo of jobs between the front and the back
// ----------------------------------------------------------------------------
module utf8d_queue #(
    parameter int DEPTH = utf8d_pkg::QUEUE_DEPTH_DEF
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            push,
    input  utf8d_pkg::job_t push_job,
    output logic            not_full,
    input  logic            pop,
    output logic            not_empty,
    output utf8d_pkg::job_t head_job
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    utf8d_pkg::job_t    slot_reg [DEPTH];
    logic [AW-1:0]      wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]      rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]      count_reg, count_next;

    assign not_full  = (count_reg != CW'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign head_job  = slot_reg[rd_ptr_reg];

    // pointer and count update
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + AW'(1);
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + AW'(1);
        end
        unique case ({push, pop})
            2'b10:   count_next = count_reg + CW'(1);
            2'b01:   count_next = count_reg - CW'(1);
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // job storage
    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

// ----- hw/rtl/utf8d_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8d_back
// takes jobs from the queue and drives the result register, splitting
// surrogate pair jobs into a high and a low unit
// ----------------------------------------------------------------------------
module utf8d_back (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            job_valid,
    input  utf8d_pkg::job_t                 job,
    output logic                            job_pop,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [utf8d_pkg::CODE_W-1:0]    m_code_unit,
    output logic [utf8d_pkg::STAT_W-1:0]    m_status,
    output logic                            m_run_last,
    output logic                            m_message_end
);

    logic                           out_valid_reg;
    logic [utf8d_pkg::CODE_W-1:0]   out_code_reg;
    logic [utf8d_pkg::STAT_W-1:0]   out_status_reg;
    logic                           out_run_last_reg;
    logic                           out_msg_end_reg;
    logic                           pend_reg;
    logic [utf8d_pkg::SURR_W-1:0]   pend_lo_reg;
    logic                           pend_msg_end_reg;

    logic                           load;
    logic [utf8d_pkg::SURR_W-1:0]   surr_hi;
    logic [utf8d_pkg::SURR_W-1:0]   surr_lo;

    // surrogate split of the head job
    assign surr_hi = utf8d_pkg::SURR_HI_BASE +
                     utf8d_pkg::SURR_W'(job.code[utf8d_pkg::CODE_W-1:10]);
    assign surr_lo = utf8d_pkg::SURR_LO_BASE | utf8d_pkg::SURR_W'(job.code[9:0]);

    assign load    = ~out_valid_reg | m_ready;
    assign job_pop = load & ~pend_reg & job_valid;

    // output register control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
            pend_reg      <= 1'b0;
        end else if (load) begin
            if (pend_reg) begin
                out_valid_reg <= 1'b1;
                pend_reg      <= 1'b0;
            end else begin
                out_valid_reg <= job_valid;
                pend_reg      <= job_valid & job.pair;
            end
        end
    end

    // output payload
    always_ff @(posedge aclk) begin
        if (load) begin
            if (pend_reg) begin
                out_code_reg     <= utf8d_pkg::CODE_W'(pend_lo_reg);
                out_status_reg   <= utf8d_pkg::ST_OK;
                out_run_last_reg <= 1'b1;
                out_msg_end_reg  <= pend_msg_end_reg;
            end else if (job_valid) begin
                out_code_reg     <= job.pair ? utf8d_pkg::CODE_W'(surr_hi) : job.code;
                out_status_reg   <= job.status;
                out_run_last_reg <= ~job.pair;
                out_msg_end_reg  <= job.msg_end;
                pend_lo_reg      <= surr_lo;
                pend_msg_end_reg <= job.msg_end;
            end
        end
    end

    assign m_valid       = out_valid_reg;
    assign m_code_unit   = out_code_reg;
    assign m_status      = out_status_reg;
    assign m_run_last    = out_run_last_reg;
    assign m_message_end = out_msg_end_reg;

endmodule

// ----- hw/rtl/utf8_decoder_unit.sv -----
`timescale 1ns / 1ps
// latency: a result is registered in the job queue, then in the result register
// throughput: one byte per cycle if the queue has room; results drain one unit per
//   cycle unless stalled; a surrogate pair holds the back end, the queue absorbs it
// bytes that close no result pass through the front without entering the queue
// reset: synchronous, active low; clears sequence state, queue, output valid,
//   and utf16_mode to 0
// ----------------------------------------------------------------------------
// utf8_decoder_unit
// streaming utf-8 decoder producing code points or utf-16 surrogate pairs,
// with a front classifier, a job queue and a result back end
// ----------------------------------------------------------------------------
module utf8_decoder_unit #(
    parameter int QUEUE_DEPTH = utf8d_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    // byte input
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [utf8d_pkg::BYTE_W-1:0]        s_byte_in,
    input  logic                                s_message_last,
    // result output
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [utf8d_pkg::CODE_W-1:0]        m_code_unit,
    output logic [utf8d_pkg::STAT_W-1:0]        m_status,
    output logic                                m_run_last,
    output logic                                m_message_end,
    // configuration
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [utf8d_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [utf8d_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [utf8d_pkg::APB_DATA_W-1:0]    prdata,
    output logic                                pready
);

    logic               utf16_mode_reg;
    logic               s_accept;
    logic               push;
    logic               q_not_full;
    logic               q_not_empty;
    logic               pop;
    utf8d_pkg::job_t    push_job;
    utf8d_pkg::job_t    head_job;

    // configuration register
    assign pready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            utf16_mode_reg <= 1'b0;
        end else if (psel && penable && pwrite && pready &&
                     paddr[2] == utf8d_pkg::REG_IDX_UTF16_MODE) begin
            utf16_mode_reg <= pwdata[0];
        end
    end

    assign prdata = (paddr[2] == utf8d_pkg::REG_IDX_UTF16_MODE) ?
                    utf8d_pkg::APB_DATA_W'(utf16_mode_reg) : '0;

    // input transfer
    assign s_ready  = q_not_full;
    assign s_accept = s_valid & s_ready;

    utf8d_front u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .accept       (s_accept),
        .byte_in      (s_byte_in),
        .message_last (s_message_last),
        .utf16_mode   (utf16_mode_reg),
        .push         (push),
        .job          (push_job)
    );

    utf8d_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_job  (push_job),
        .not_full  (q_not_full),
        .pop       (pop),
        .not_empty (q_not_empty),
        .head_job  (head_job)
    );

    utf8d_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .job_valid     (q_not_empty),
        .job           (head_job),
        .job_pop       (pop),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_code_unit   (m_code_unit),
        .m_status      (m_status),
        .m_run_last    (m_run_last),
        .m_message_end (m_message_end)
    );

endmodule

// ----- hw/rtl/utf8d_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8d_checker
// port-level checks of the decoder result stream, bound to the top level
// ----------------------------------------------------------------------------
module utf8d_checker (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                m_valid,
    input  logic                                m_ready,
    input  logic [utf8d_pkg::CODE_W-1:0]        m_code_unit,
    input  logic [utf8d_pkg::STAT_W-1:0]        m_status,
    input  logic                                m_run_last,
    input  logic                                m_message_end
);

    // stalled result transfer holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_code_unit) &&
        $stable(m_status) && $stable(m_run_last) && $stable(m_message_end))
        else $error("result changed while stalled");

    // error results carry a zero code unit
    a_err_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status != utf8d_pkg::ST_OK |-> m_code_unit == '0 && m_run_last)
        else $error("error result with nonzero code unit");

    // too-few only at the end of a message
    a_toofew_end: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status == utf8d_pkg::ST_TOOFEW |-> m_message_end)
        else $error("too-few result outside message end");

    // high surrogate is followed at once by its low half
    a_pair_follow: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && !m_run_last |=>
        m_valid && m_run_last && m_status == utf8d_pkg::ST_OK &&
        m_code_unit[utf8d_pkg::CODE_W-1:10] == 11'h037)
        else $error("surrogate pair not completed");

endmodule

bind utf8_decoder_unit utf8d_checker u_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_code_unit   (m_code_unit),
    .m_status      (m_status),
    .m_run_last    (m_run_last),
    .m_message_end (m_message_end)
);
